// ----- rtl/msup_pkg.sv -----
// Shared types, register indexes and constants of the motor safety supervisor.
package msup_pkg;

	// Width of the duty path. The result duty and the full-scale value follow from it.
	localparam int DUTY_WIDTH = 12;
	localparam int CALC_WIDTH = 17;
	localparam logic [CALC_WIDTH-1:0] DUTY_FULL = CALC_WIDTH'((1 << DUTY_WIDTH) - 1);

	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH = 16;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_OVERCURRENT = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEADLINE = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_CEILING = 2'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RAMP_STEP = 2'd3;

	localparam logic [15:0] OVERCURRENT_RESET = 16'd4200;
	localparam logic [15:0] DEADLINE_RESET = 16'd50;
	localparam logic [11:0] CEILING_RESET = 12'd1000;
	localparam logic [7:0] RAMP_STEP_RESET = 8'd10;

	localparam logic [1:0] MODE_INIT = 2'd0;
	localparam logic [1:0] MODE_ARMED = 2'd1;
	localparam logic [1:0] MODE_RUNNING = 2'd2;
	localparam logic [1:0] MODE_SAFE = 2'd3;

	localparam logic [1:0] CAUSE_NONE = 2'd0;
	localparam logic [1:0] CAUSE_OVERCURRENT = 2'd1;
	localparam logic [1:0] CAUSE_DEADLINE = 2'd2;

	typedef struct packed {
		logic [15:0] current_ma;
		logic [15:0] update_age;
		logic [11:0] target_duty;
	} in_item_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [DUTY_WIDTH-1:0] duty;
		logic [1:0] fault_cause;
	} out_item_t;

	typedef struct packed {
		logic [15:0] overcurrent_limit;
		logic [15:0] deadline_limit;
		logic [11:0] duty_ceiling;
		logic [7:0] ramp_step;
	} cfg_regs_t;

	// Supervisor state; it has the same shape as a result beat.
	typedef out_item_t state_word_t;

endpackage

// ----- rtl/motor_safety_supervisor_unit.sv -----
// Top level of the motor safety supervisor: input register, state, result register.
// Usage:
// Each beat on the input channel (in_valid/in_ready/in_item) is one supervisor tick
// carrying the measured current, the sensor update age and the duty setpoint.
// Every tick yields exactly one result beat on the output channel
// (out_valid/out_ready/out_item) with the mode, duty and latched fault cause.
// The tick is first captured in the input register; the limit checks, mode walk and
// duty ramp are then computed in a single pass and written together into the
// supervisor state and the result register, which drives the output channel.
// A new tick can be accepted every cycle, so throughput is one beat per cycle while
// the receiver keeps up.
// If the receiver stalls, the result register holds its beat, the tick in the input
// register waits, and in_ready drops only when both are occupied and the receiver is
// not ready, so no beat is lost or repeated.
// The configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always
// ready and writes one register per beat; write it only while no ticks are in flight.
// Reset puts the block in init mode with duty zero and no fault, loads the default
// limits and empties both registers. The safe mode, once entered, holds until reset.
module motor_safety_supervisor_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  msup_pkg::in_item_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output msup_pkg::out_item_t out_item,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [msup_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [msup_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);

	msup_pkg::cfg_regs_t regs;
	msup_pkg::in_item_t item_s1;
	logic valid_s1;
	msup_pkg::state_word_t state_q;
	msup_pkg::state_word_t state_nxt;
	msup_pkg::out_item_t result_q;
	logic result_valid_q;
	logic advance;

	// The configuration registers accept a write in any cycle.
	assign cfg_ready = 1'b1;

	msup_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cfg_valid && cfg_ready),
		.wr_index(cfg_index),
		.wr_data(cfg_data),
		.regs(regs)
	);

	// A tick moves from the input register into the state and the result register
	// whenever the result register is empty or is being drained this cycle.
	assign advance = valid_s1 && (!result_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	msup_step u_step (
		.regs(regs),
		.cur(state_q),
		.item(item_s1),
		.nxt(state_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode <= msup_pkg::MODE_INIT;
			state_q.duty <= '0;
			state_q.fault_cause <= msup_pkg::CAUSE_NONE;
			result_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (out_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= state_nxt;
		end
	end

	assign out_valid = result_valid_q;
	assign out_item = result_q;

	// Safe mode always reports zero duty.
	a_safe_duty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.mode == msup_pkg::MODE_SAFE) |-> (out_item.duty == '0))
		else $error("safe mode result with nonzero duty");

	// A fault cause is recorded exactly when the supervisor is in safe mode.
	a_cause_matches_mode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_item.mode == msup_pkg::MODE_SAFE) ==
		(out_item.fault_cause != msup_pkg::CAUSE_NONE)))
		else $error("fault cause and safe mode disagree");

	// Safe mode is sticky until reset, and so is its cause.
	a_safe_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.mode == msup_pkg::MODE_SAFE) |=>
		(state_q.mode == msup_pkg::MODE_SAFE && $stable(state_q.fault_cause)))
		else $error("safe mode left before reset");

	// With both registers full and the receiver stalled, no new tick is taken.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && result_valid_q && !out_ready) |-> !in_ready)
		else $error("input accepted while pipeline is full");

	// The state only changes when a tick is processed.
	a_state_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("supervisor state changed without a tick");

endmodule

// ----- rtl/msup_cfg.sv -----
// Configuration register file of the motor safety supervisor.
module msup_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [msup_pkg::CFG_INDEX_WIDTH-1:0] wr_index,
	input  logic [msup_pkg::CFG_DATA_WIDTH-1:0] wr_data,
	output msup_pkg::cfg_regs_t regs
);

	msup_pkg::cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.overcurrent_limit <= msup_pkg::OVERCURRENT_RESET;
			regs_q.deadline_limit <= msup_pkg::DEADLINE_RESET;
			regs_q.duty_ceiling <= msup_pkg::CEILING_RESET;
			regs_q.ramp_step <= msup_pkg::RAMP_STEP_RESET;
		end else if (wr_en) begin
			case (wr_index)
				msup_pkg::REG_OVERCURRENT: regs_q.overcurrent_limit <= wr_data;
				msup_pkg::REG_DEADLINE: regs_q.deadline_limit <= wr_data;
				msup_pkg::REG_CEILING: regs_q.duty_ceiling <= wr_data[11:0];
				msup_pkg::REG_RAMP_STEP: regs_q.ramp_step <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// ----- rtl/msup_step.sv -----
// Next-state logic of the supervisor for one tick: limit checks, mode walk and duty ramp.
module msup_step (
	input  msup_pkg::cfg_regs_t regs,
	input  msup_pkg::state_word_t cur,
	input  msup_pkg::in_item_t item,
	output msup_pkg::state_word_t nxt
);

	localparam int CW = msup_pkg::CALC_WIDTH;

	logic [CW-1:0] duty_w;
	logic [CW-1:0] target_w;
	logic [CW-1:0] step_w;
	logic [CW-1:0] ceil_w;
	logic [CW-1:0] limit_w;
	logic [CW-1:0] ramped_w;
	logic [CW-1:0] clamped_w;

	always_comb begin
		duty_w = CW'(cur.duty);
		target_w = CW'(item.target_duty);
		step_w = CW'(regs.ramp_step);
		ceil_w = CW'(regs.duty_ceiling);
		limit_w = (ceil_w > msup_pkg::DUTY_FULL) ? msup_pkg::DUTY_FULL : ceil_w;

		if (duty_w < target_w) begin
			ramped_w = duty_w + step_w;
		end else if (duty_w > target_w) begin
			ramped_w = (duty_w > step_w) ? duty_w - step_w : '0;
		end else begin
			ramped_w = duty_w;
		end
		clamped_w = (ramped_w > limit_w) ? limit_w : ramped_w;
	end

	always_comb begin
		nxt = cur;
		if (cur.mode == msup_pkg::MODE_SAFE) begin
			nxt.duty = '0;
		end else if (item.current_ma > regs.overcurrent_limit) begin
			nxt.mode = msup_pkg::MODE_SAFE;
			nxt.duty = '0;
			nxt.fault_cause = msup_pkg::CAUSE_OVERCURRENT;
		end else if (item.update_age > regs.deadline_limit) begin
			nxt.mode = msup_pkg::MODE_SAFE;
			nxt.duty = '0;
			nxt.fault_cause = msup_pkg::CAUSE_DEADLINE;
		end else if (cur.mode == msup_pkg::MODE_INIT) begin
			nxt.mode = msup_pkg::MODE_ARMED;
		end else if (cur.mode == msup_pkg::MODE_ARMED) begin
			nxt.mode = msup_pkg::MODE_RUNNING;
		end else begin
			nxt.duty = clamped_w[msup_pkg::DUTY_WIDTH-1:0];
		end
	end

endmodule
